### rtl/urm_pkg.sv
// ----------------------------------------------------------------------------
// UART register model package
// Command codes, register offsets and write masks shared by the block.
// ----------------------------------------------------------------------------
package urm_pkg;

   localparam logic [1:0] CMD_BUS_READ  = 2'd0;
   localparam logic [1:0] CMD_BUS_WRITE = 2'd1;
   localparam logic [1:0] CMD_HOST_BYTE = 2'd2;
   localparam logic [1:0] CMD_TICK      = 2'd3;

   localparam logic [2:0] REG_BUFFER    = 3'd0;
   localparam logic [2:0] REG_CONTROL   = 3'd1;
   localparam logic [2:0] REG_MODE0     = 3'd2;
   localparam logic [2:0] REG_MODE1     = 3'd3;
   localparam logic [2:0] REG_BAUD_LOW  = 3'd4;
   localparam logic [2:0] REG_BAUD_HIGH = 3'd5;
   localparam logic [2:0] REG_STATUS    = 3'd6;

   localparam logic [4:0] MODE0_MASK = 5'b10111;
   localparam logic [6:0] MODE1_MASK = 7'h7f;

   typedef logic [1:0] command_type;
   typedef logic [2:0] offset_type;
   typedef logic [7:0] byte_type;

endpackage

### rtl/urm_if.sv
// ----------------------------------------------------------------------------
// UART register model channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
interface urm_req_if;
   import urm_pkg::*;

   logic        valid;
   logic        ready;
   command_type command;
   offset_type  reg_offset;
   byte_type    write_data;
   byte_type    rx_byte;

   modport source (output valid, command, reg_offset, write_data, rx_byte, input ready);
   modport sink (input valid, command, reg_offset, write_data, rx_byte, output ready);
endinterface

interface urm_rsp_if;
   import urm_pkg::*;

   logic     valid;
   logic     ready;
   byte_type read_data;
   logic     tx_valid;
   byte_type tx_byte;
   logic     rx_dropped;

   modport source (output valid, read_data, tx_valid, tx_byte, rx_dropped, input ready);
   modport sink (input valid, read_data, tx_valid, tx_byte, rx_dropped, output ready);
endinterface

### rtl/urm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module urm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/uart_register_model.sv
// ----------------------------------------------------------------------------
// UART register model
// Byte-wide UART register window with a receive FIFO.
// ----------------------------------------------------------------------------
// Each request carries a command: a bus read or write of one register, a
// host byte to be pushed into the receive FIFO, or a tick that samples the
// status flag. Every request produces exactly one response with the read
// data, a transmitted byte with its valid flag and a drop flag.
// A request is registered on acceptance and executed once the response
// register is free or its response is taken, when the result is loaded
// into the response register. One request is accepted every cycle while
// the response receiver does not stall. The FIFO storage sits in a RAM
// with registered read; the read port always addresses the next head slot
// and a one-entry bypass covers a byte written in the previous cycle.
// Reset clears the valid flags, configuration, status and FIFO pointers,
// empties the FIFO and drops any request in flight; it needs no clearing
// pass. While the response receiver stalls, the held response stays,
// one further request is buffered and the request side then stalls.
// ----------------------------------------------------------------------------
module uart_register_model #(
   parameter int FIFO_DEPTH = 16
) (
   input logic      clock,
   input logic      reset,
   urm_req_if.sink  req,
   urm_rsp_if.source rsp
);
   import urm_pkg::*;

   localparam int PTR_W   = $clog2(FIFO_DEPTH);
   localparam int COUNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(FIFO_DEPTH);
   localparam logic [PTR_W-1:0]   LAST_SLOT  = PTR_W'(FIFO_DEPTH - 1);

   logic         req_valid_ff, req_valid_in;
   command_type  cmd_ff;
   offset_type   off_ff;
   byte_type     wdata_ff;
   byte_type     rxb_ff;

   logic         control_ff, control_in;
   logic [4:0]   mode0_ff, mode0_in;
   logic [6:0]   mode1_ff, mode1_in;
   logic [11:0]  baud_ff, baud_in;
   logic         status_ff, status_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;

   logic         byp_hit_ff, byp_hit_in;
   byte_type     byp_data_ff;
   byte_type     ram_rd_data;
   byte_type     head_data;
   logic         fifo_we;

   logic         rsp_valid_ff, rsp_valid_in;
   byte_type     read_data_ff, read_data_in;
   logic         tx_valid_ff, tx_valid_in;
   byte_type     tx_byte_ff, tx_byte_in;
   logic         rx_dropped_ff, rx_dropped_in;

   logic         advance;
   logic         req_accept;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready  = !req_valid_ff || advance;
   assign req_accept = req.valid && req.ready;
   assign head_data  = byp_hit_ff ? byp_data_ff : ram_rd_data;

   always_comb begin
      req_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : req_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      control_in    = control_ff;
      mode0_in      = mode0_ff;
      mode1_in      = mode1_ff;
      baud_in       = baud_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fifo_we       = 1'b0;
      read_data_in  = '0;
      tx_valid_in   = 1'b0;
      tx_byte_in    = '0;
      rx_dropped_in = 1'b0;
      if (advance) begin
         case (cmd_ff)
            CMD_BUS_READ: begin
               case (off_ff)
                  REG_BUFFER: begin
                     if (mode0_ff[0] && control_ff && count_ff != '0) begin
                        read_data_in = head_data;
                        head_in      = next_slot(head_ff);
                        count_in     = count_ff - 1'b1;
                     end
                  end
                  REG_CONTROL:   read_data_in = {7'd0, control_ff};
                  REG_MODE0:     read_data_in = {3'd0, mode0_ff};
                  REG_MODE1:     read_data_in = {1'b0, mode1_ff};
                  REG_BAUD_LOW:  read_data_in = baud_ff[7:0];
                  REG_BAUD_HIGH: read_data_in = {4'd0, baud_ff[11:8]};
                  REG_STATUS:    read_data_in = {7'd0, status_ff};
                  default:       read_data_in = '0;
               endcase
            end
            CMD_BUS_WRITE: begin
               case (off_ff)
                  REG_BUFFER: begin
                     if (!mode0_ff[0] && control_ff) begin
                        tx_valid_in = 1'b1;
                        tx_byte_in  = wdata_ff;
                     end
                  end
                  REG_CONTROL:   control_in = wdata_ff[0];
                  REG_MODE0:     mode0_in   = wdata_ff[4:0] & MODE0_MASK;
                  REG_MODE1:     mode1_in   = wdata_ff[6:0] & MODE1_MASK;
                  REG_BAUD_LOW:  baud_in    = {baud_ff[11:8], wdata_ff};
                  REG_BAUD_HIGH: baud_in    = {wdata_ff[3:0], baud_ff[7:0]};
                  REG_STATUS:    status_in  = 1'b0;
                  default:       control_in = control_ff;
               endcase
            end
            CMD_HOST_BYTE: begin
               if (count_ff == FULL_COUNT) begin
                  rx_dropped_in = 1'b1;
               end else begin
                  fifo_we  = 1'b1;
                  tail_in  = next_slot(tail_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            default: begin
               status_in = mode0_ff[0] && (count_ff != '0);
            end
         endcase
      end
      byp_hit_in = fifo_we && (tail_ff == head_in);
   end

   urm_ram #(
      .WIDTH (8),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (tail_ff),
      .wr_data (rxb_ff),
      .rd_addr (head_in),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         control_ff   <= 1'b0;
         mode0_ff     <= '0;
         mode1_ff     <= '0;
         baud_ff      <= '0;
         status_ff    <= 1'b0;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         byp_hit_ff   <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         control_ff   <= control_in;
         mode0_ff     <= mode0_in;
         mode1_ff     <= mode1_in;
         baud_ff      <= baud_in;
         status_ff    <= status_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         byp_hit_ff   <= byp_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req.command;
         off_ff   <= req.reg_offset;
         wdata_ff <= req.write_data;
         rxb_ff   <= req.rx_byte;
      end
      if (advance) begin
         read_data_ff  <= read_data_in;
         tx_valid_ff   <= tx_valid_in;
         tx_byte_ff    <= tx_byte_in;
         rx_dropped_ff <= rx_dropped_in;
      end
      byp_data_ff <= rxb_ff;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.read_data  = read_data_ff;
   assign rsp.tx_valid   = tx_valid_ff;
   assign rsp.tx_byte    = tx_byte_ff;
   assign rsp.rx_dropped = rx_dropped_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("FIFO count exceeds depth");

   a_ptr_align: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_COUNT) |-> head_ff == tail_ff)
      else $error("FIFO pointers disagree with count");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && tx_valid_ff) |-> (read_data_ff == '0 && !rx_dropped_ff))
      else $error("Transmit response carries other results");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (advance && cmd_ff == CMD_HOST_BYTE && count_ff == FULL_COUNT)
         |=> (rsp_valid_ff && rx_dropped_ff && $stable(tail_ff)))
      else $error("Host byte at full FIFO was not dropped");
endmodule
